>>> rtl/core/lmfb_pkg.sv
// Package for the LED matrix frame buffer refresh core.
// Holds the word types, input kinds, driver register addresses and sequencer types.
// Depends on nothing; every module of the core imports it.
`default_nettype none

package lmfb_pkg;

	localparam logic [2:0] KIND_CLEAR   = 3'd0;
	localparam logic [2:0] KIND_PIXEL   = 3'd1;
	localparam logic [2:0] KIND_COLUMN  = 3'd2;
	localparam logic [2:0] KIND_REFRESH = 3'd3;
	localparam logic [2:0] KIND_INIT    = 3'd4;

	localparam logic [1:0] CFG_NUM_COLS  = 2'd0;
	localparam logic [1:0] CFG_NUM_ROWS  = 2'd1;
	localparam logic [1:0] CFG_INTENSITY = 2'd2;

	localparam logic [4:0] NUM_COLS_RST  = 5'd24;
	localparam logic [3:0] NUM_ROWS_RST  = 4'd8;
	localparam logic [3:0] INTENSITY_RST = 4'd15;

	localparam logic [3:0] RG_SHUTDOWN  = 4'hC;
	localparam logic [3:0] RG_TEST      = 4'hF;
	localparam logic [3:0] RG_DECODE    = 4'h9;
	localparam logic [3:0] RG_SCAN      = 4'hB;
	localparam logic [3:0] RG_INTENSITY = 4'hA;
	localparam logic [7:0] SCAN_ALL     = 8'h07;
	localparam logic [7:0] TOP_BIT      = 8'h80;

	localparam logic [3:0] STEP_SHUTDOWN  = 4'd0;
	localparam logic [3:0] STEP_TEST      = 4'd1;
	localparam logic [3:0] STEP_DECODE    = 4'd2;
	localparam logic [3:0] STEP_SCAN      = 4'd3;
	localparam logic [3:0] STEP_INTENSITY = 4'd4;
	localparam logic [3:0] STEP_DIGIT0    = 4'd5;
	localparam logic [3:0] STEP_INIT_LAST = 4'd12;
	localparam logic [3:0] STEP_ROW_LAST  = 4'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] x;
		logic [7:0] y;
		logic       pixel_value;
		logic [7:0] column_bits;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0] reg_address;
		logic [7:0] reg_data;
		logic       frame_end;
		logic       last;
	} out_word_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic apply;
		logic start;
		logic advance;
	} ctl_t;

	typedef struct packed {
		logic is_run;
		logic word_last;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/led_matrix_frame_buffer_refresh_core.sv
// Top level of the LED matrix frame buffer refresh core.
// Instantiates lmfb_ctrl and lmfb_dp; uses lmfb_pkg.
//
// The core keeps the frame buffer of a chain of MODULES 8x8 LED matrix driver
// chips and turns refresh and initialise commands into driver register words.
// Commands arrive on the cmd channel (cmd_valid, cmd_ready, cmd_data); words
// leave on the word channel (word_valid, word_ready, word_data). The cfg channel
// writes num_cols, num_rows and intensity and is always ready.
// Clear, pixel and column commands update the buffer in the cycle they are
// accepted, produce no word, and the next command can be taken in the cycle after.
// A refresh gives 8*MODULES words and an initialise 13*MODULES words; the first
// word is valid in the cycle after the command, then one word leaves per cycle
// while word_ready is high, as paced by the row and module counters. A new
// command is accepted in the cycle after the last word has been taken.
// When the receiver stalls the current word is held and the counters stop.
// Reset clears the whole buffer at once and loads the register defaults.
`default_nettype none

module led_matrix_frame_buffer_refresh_core #(
	parameter int MODULES = 3
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_ready,
	input  lmfb_pkg::cmd_word_t cmd_data,
	output logic                word_valid,
	input  wire                 word_ready,
	output lmfb_pkg::out_word_t word_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [4:0]          cfg_data
);
	import lmfb_pkg::*;

	ctl_t    ctl;
	status_t status;

	assign cfg_ready = 1'b1;

	lmfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.status     (status),
		.ctl        (ctl)
	);

	lmfb_dp #(
		.MODULES (MODULES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.ctl       (ctl),
		.status    (status),
		.word      (word_data),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && word_valid))
		else $error("Command taken while a word run is in progress.");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready &&
		 (cmd_data.kind == KIND_REFRESH || cmd_data.kind == KIND_INIT)) |=> word_valid)
		else $error("Run command did not start a word sequence.");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_ready && word_data.last) |=> (cmd_ready && !word_valid))
		else $error("Core did not return to idle after the last word.");

	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_data.last) |-> word_data.frame_end)
		else $error("Last word of a run does not close a frame.");

endmodule

`default_nettype wire

>>> rtl/core/lmfb_ctrl.sv
// Controller state machine of the LED matrix frame buffer refresh core.
// Drives the handshakes and commands the datapath; uses lmfb_pkg.
`default_nettype none

module lmfb_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	output logic              cmd_ready,
	output logic              word_valid,
	input  wire               word_ready,
	input  lmfb_pkg::status_t status,
	output lmfb_pkg::ctl_t    ctl
);
	import lmfb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && status.is_run) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (word_ready && status.word_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready   = 1'b0;
		word_valid  = 1'b0;
		ctl.apply   = 1'b0;
		ctl.start   = 1'b0;
		ctl.advance = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ctl.apply = cmd_valid;
				ctl.start = cmd_valid && status.is_run;
			end
			ST_EMIT: begin
				word_valid  = 1'b1;
				ctl.advance = word_ready;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/lmfb_dp.sv
// Datapath of the LED matrix frame buffer refresh core.
// Holds the configuration registers, the frame buffer and the word sequence counters.
// Depends on lmfb_pkg.
`default_nettype none

module lmfb_dp #(
	parameter int MODULES = 3
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lmfb_pkg::cmd_word_t cmd_data,
	input  lmfb_pkg::ctl_t      ctl,
	output lmfb_pkg::status_t   status,
	output lmfb_pkg::out_word_t word,
	input  wire                 cfg_write,
	input  wire  [1:0]          cfg_index,
	input  wire  [4:0]          cfg_data
);
	import lmfb_pkg::*;

	localparam int FB_DEPTH = 8 * MODULES;
	localparam int IDX_W    = $clog2(FB_DEPTH);
	localparam int MOD_W    = (MODULES > 1) ? $clog2(MODULES) : 1;

	logic [4:0] num_cols_q;
	logic [3:0] num_rows_q;
	logic [3:0] intensity_q;

	logic [7:0] fb_q [FB_DEPTH];
	logic [7:0] fb_d [FB_DEPTH];

	logic             init_q;
	logic [3:0]       grp_q;
	logic [MOD_W-1:0] mod_q;

	logic             col_ok;
	logic             pix_ok;
	logic [MOD_W-1:0] wr_mod;
	logic [7:0]       bit_mask;
	logic             mod_end;
	logic [IDX_W-1:0] rd_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q  <= NUM_COLS_RST;
			num_rows_q  <= NUM_ROWS_RST;
			intensity_q <= INTENSITY_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_NUM_COLS:  num_cols_q  <= cfg_data;
				CFG_NUM_ROWS:  num_rows_q  <= cfg_data[3:0];
				CFG_INTENSITY: intensity_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign col_ok   = ({3'b000, num_cols_q} > cmd_data.x) && (cmd_data.x[7:3] < 5'(MODULES));
	assign pix_ok   = col_ok && ({4'b0000, num_rows_q} > cmd_data.y) && (cmd_data.y[7:3] == 5'd0);
	assign wr_mod   = MOD_W'(MODULES - 1) - cmd_data.x[3 +: MOD_W];
	assign bit_mask = TOP_BIT >> cmd_data.x[2:0];

	for (genvar e = 0; e < FB_DEPTH; e++) begin : g_fb
		localparam int ROW  = e / MODULES;
		localparam int MCOL = e % MODULES;

		always_comb begin
			fb_d[e] = fb_q[e];
			if (ctl.apply) begin
				case (cmd_data.kind)
					KIND_CLEAR: fb_d[e] = 8'h00;
					KIND_PIXEL: begin
						if (pix_ok && (wr_mod == MOD_W'(MCOL)) && (cmd_data.y[2:0] == 3'(ROW))) begin
							fb_d[e] = cmd_data.pixel_value ? (fb_q[e] | bit_mask)
							                               : (fb_q[e] & ~bit_mask);
						end
					end
					KIND_COLUMN: begin
						if (col_ok && (wr_mod == MOD_W'(MCOL))) begin
							fb_d[e] = cmd_data.column_bits[7 - ROW] ? (fb_q[e] | bit_mask)
							                                       : (fb_q[e] & ~bit_mask);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FB_DEPTH; i++) begin
				fb_q[i] <= 8'h00;
			end
		end else begin
			for (int i = 0; i < FB_DEPTH; i++) begin
				fb_q[i] <= fb_d[i];
			end
		end
	end

	assign mod_end = (mod_q == MOD_W'(MODULES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			grp_q  <= 4'd0;
			mod_q  <= '0;
		end else if (ctl.start) begin
			init_q <= (cmd_data.kind == KIND_INIT);
			grp_q  <= 4'd0;
			mod_q  <= '0;
		end else if (ctl.advance) begin
			if (mod_end) begin
				mod_q <= '0;
				grp_q <= grp_q + 4'd1;
			end else begin
				mod_q <= mod_q + MOD_W'(1);
			end
		end
	end

	assign status.is_run    = (cmd_data.kind == KIND_REFRESH) || (cmd_data.kind == KIND_INIT);
	assign status.word_last = mod_end && (grp_q == (init_q ? STEP_INIT_LAST : STEP_ROW_LAST));

	assign rd_idx = IDX_W'(int'(grp_q[2:0]) * MODULES + int'(mod_q));

	always_comb begin
		word.frame_end = mod_end;
		word.last      = status.word_last;
		if (init_q) begin
			case (grp_q)
				STEP_SHUTDOWN: begin
					word.reg_address = RG_SHUTDOWN;
					word.reg_data    = 8'h01;
				end
				STEP_TEST: begin
					word.reg_address = RG_TEST;
					word.reg_data    = 8'h00;
				end
				STEP_DECODE: begin
					word.reg_address = RG_DECODE;
					word.reg_data    = 8'h00;
				end
				STEP_SCAN: begin
					word.reg_address = RG_SCAN;
					word.reg_data    = SCAN_ALL;
				end
				STEP_INTENSITY: begin
					word.reg_address = RG_INTENSITY;
					word.reg_data    = {4'h0, intensity_q};
				end
				default: begin
					word.reg_address = grp_q - (STEP_DIGIT0 - 4'd1);
					word.reg_data    = 8'h00;
				end
			endcase
		end else begin
			word.reg_address = grp_q + 4'd1;
			word.reg_data    = fb_q[rd_idx];
		end
	end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the LED matrix frame buffer refresh core.
// Drives commands and register writes, predicts every driver word and checks it.
// Depends on lmfb_pkg and led_matrix_frame_buffer_refresh_core only.
`timescale 1ns / 100ps

module testbench;
	import lmfb_pkg::*;

	localparam int MODULES = 3;
	localparam int FB_BYTES = 8 * MODULES;
	localparam logic [2:0] KIND_SPARE_LO = KIND_INIT + 3'd1;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PER_PHASE = 50;

	class led_frame_model;
		logic [7:0] pixels [FB_BYTES];
		logic [4:0] num_cols;
		logic [3:0] num_rows;
		logic [3:0] intensity;
		out_word_t pending_words [$];
		int mismatches;
		int words_seen;
		int commands_taken;

		function void clear_state();
			foreach (pixels[i])
				pixels[i] = 8'h00;
			num_cols = NUM_COLS_RST;
			num_rows = NUM_ROWS_RST;
			intensity = INTENSITY_RST;
		endfunction

		function void write_register(logic [1:0] index, logic [4:0] value);
			case (index)
				CFG_NUM_COLS: num_cols = value;
				CFG_NUM_ROWS: num_rows = value[3:0];
				CFG_INTENSITY: intensity = value[3:0];
				default: ;
			endcase
		endfunction

		function bit column_active(int x);
			return x < int'(num_cols) && x / 8 < MODULES;
		endfunction

		function void put_bit(int x, int row, logic v);
			int idx;
			idx = (MODULES - 1 - x / 8) + MODULES * row;
			if (idx < FB_BYTES)
				pixels[idx][7 - (x % 8)] = v;
		endfunction

		function void push_word(int address, logic [7:0] data, bit fend, bit lst);
			out_word_t w;
			w.reg_address = 4'(address);
			w.reg_data = data;
			w.frame_end = fend;
			w.last = lst;
			pending_words.push_back(w);
		endfunction

		function void take_command(cmd_word_t c);
			int x;
			int y;
			int address;
			logic [7:0] data;
			x = int'(c.x);
			y = int'(c.y);
			commands_taken++;
			case (c.kind)
				KIND_CLEAR: begin
					foreach (pixels[i])
						pixels[i] = 8'h00;
				end
				KIND_PIXEL: begin
					if (column_active(x) && y < int'(num_rows) && y < 8)
						put_bit(x, y, c.pixel_value);
				end
				KIND_COLUMN: begin
					if (column_active(x))
						for (int r = 0; r < 8; r++)
							put_bit(x, r, c.column_bits[7 - r]);
				end
				KIND_REFRESH: begin
					for (int r = 0; r < 8; r++)
						for (int m = 0; m < MODULES; m++)
							push_word(r + 1, pixels[m + MODULES * r], m == MODULES - 1,
								m == MODULES - 1 && r == int'(STEP_ROW_LAST));
				end
				KIND_INIT: begin
					for (int g = 0; g <= int'(STEP_INIT_LAST); g++) begin
						case (4'(g))
							STEP_SHUTDOWN: begin address = RG_SHUTDOWN; data = 8'h01; end
							STEP_TEST: begin address = RG_TEST; data = 8'h00; end
							STEP_DECODE: begin address = RG_DECODE; data = 8'h00; end
							STEP_SCAN: begin address = RG_SCAN; data = SCAN_ALL; end
							STEP_INTENSITY: begin address = RG_INTENSITY; data = {4'h0, intensity}; end
							default: begin address = g - int'(STEP_DIGIT0) + 1; data = 8'h00; end
						endcase
						for (int m = 0; m < MODULES; m++)
							push_word(address, data, m == MODULES - 1,
								m == MODULES - 1 && g == int'(STEP_INIT_LAST));
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				mismatches++;
				$display("%0t ns: word %0d %s expected %0h, got %0h", $time, words_seen, name,
					want, got);
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			words_seen++;
			if (pending_words.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected word, expected none, got %h", $time, got);
				return;
			end
			want = pending_words.pop_front();
			compare_field("reg_address", want.reg_address, got.reg_address);
			compare_field("reg_data", want.reg_data, got.reg_data);
			compare_field("frame_end", want.frame_end, got.frame_end);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_word_t cmd_data;
	logic word_valid;
	logic word_ready;
	out_word_t word_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	led_frame_model model;
	bit calm;
	int cycles;
	int settings_used;

	led_matrix_frame_buffer_refresh_core #(
		.MODULES(MODULES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data(cmd_data),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word_data(word_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words outstanding.", cycles,
				model.pending_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_valid && word_ready)
			model.check_word(word_data);
	end

	function int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		int hold;
		hold = 0;
		word_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				word_ready = 1'b0;
				hold--;
			end else begin
				hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				word_ready = (hold == 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	function cmd_word_t make_cmd(logic [2:0] kind, logic [7:0] x, logic [7:0] y, logic pv,
		logic [7:0] bits);
		cmd_word_t c;
		c.kind = kind;
		c.x = x;
		c.y = y;
		c.pixel_value = pv;
		c.column_bits = bits;
		return c;
	endfunction

	function cmd_word_t random_cmd();
		cmd_word_t c;
		int r;
		c = make_cmd(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
		if ($urandom_range(0, 7) != 0)
			c.x = 8'($urandom_range(0, 31));
		if ($urandom_range(0, 7) != 0)
			c.y = 8'($urandom_range(0, 9));
		r = $urandom_range(0, 99);
		if (r < 45)
			c.kind = KIND_PIXEL;
		else if (r < 75)
			c.kind = KIND_COLUMN;
		else if (r < 88)
			c.kind = KIND_REFRESH;
		else if (r < 93)
			c.kind = KIND_INIT;
		else if (r < 96)
			c.kind = KIND_CLEAR;
		else
			c.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		return c;
	endfunction

	task send_cmd(cmd_word_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid = 1'b1;
		cmd_data = c;
		do @(posedge clk); while (!cmd_ready);
		model.take_command(c);
	endtask

	task write_cfg(logic [1:0] index, logic [4:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		model.write_register(index, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task drain();
		int waited;
		@(negedge clk);
		cmd_valid = 1'b0;
		waited = 0;
		while (model.pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (model.pending_words.size() != 0) begin
			$display("%0t ns: %0d expected words never arrived, expected %h first", $time,
				model.pending_words.size(), model.pending_words[0]);
			model.mismatches += model.pending_words.size();
			model.pending_words.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task configure(logic [4:0] cols, logic [4:0] rows, logic [4:0] level);
		write_cfg(CFG_NUM_COLS, cols);
		write_cfg(CFG_NUM_ROWS, rows);
		write_cfg(CFG_INTENSITY, level);
		settings_used++;
	endtask

	task random_phase();
		repeat (RANDOM_PER_PHASE)
			send_cmd(random_cmd());
		drain();
	endtask

	initial begin
		model = new();
		model.clear_state();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NUM_COLS;
		cfg_data = '0;
		calm = 1'b0;
		cycles = 0;
		settings_used = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_cmd(make_cmd(KIND_INIT, 8'h00, 8'h00, 1'b0, 8'h00));
		send_cmd(make_cmd(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 8'h00));
		send_cmd(make_cmd(KIND_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00));
		send_cmd(make_cmd(KIND_PIXEL, 8'd23, 8'd7, 1'b1, 8'h00));
		send_cmd(make_cmd(KIND_PIXEL, 8'd24, 8'd0, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_PIXEL, 8'd5, 8'd8, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_PIXEL, 8'hFF, 8'hFF, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_COLUMN, 8'd8, 8'hFF, 1'b0, 8'hA5));
		send_cmd(make_cmd(KIND_COLUMN, 8'd23, 8'd0, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_COLUMN, 8'd200, 8'd0, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_PIXEL, 8'd23, 8'd7, 1'b0, 8'h00));
		send_cmd(make_cmd(KIND_SPARE_LO, 8'd1, 8'd1, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_SPARE_HI, 8'd2, 8'd2, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_REFRESH, 8'hFF, 8'hFF, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'hFF));
		send_cmd(make_cmd(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 8'h00));
		send_cmd(make_cmd(KIND_COLUMN, 8'd0, 8'd0, 1'b0, 8'h80));
		send_cmd(make_cmd(KIND_COLUMN, 8'd15, 8'd0, 1'b0, 8'h01));
		send_cmd(make_cmd(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 8'h00));
		drain();

		configure(5'd1, 5'd1, 5'd0);
		send_cmd(make_cmd(KIND_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00));
		send_cmd(make_cmd(KIND_PIXEL, 8'd1, 8'd0, 1'b1, 8'h00));
		send_cmd(make_cmd(KIND_PIXEL, 8'd0, 8'd1, 1'b1, 8'h00));
		send_cmd(make_cmd(KIND_COLUMN, 8'd0, 8'd0, 1'b0, 8'h5A));
		send_cmd(make_cmd(KIND_INIT, 8'h00, 8'h00, 1'b0, 8'h00));
		send_cmd(make_cmd(KIND_REFRESH, 8'h00, 8'h00, 1'b0, 8'h00));
		drain();

		configure(5'd24, 5'd8, 5'd15);
		random_phase();
		configure(5'd1, 5'd1, 5'd0);
		random_phase();
		// The sender and the receiver run without gaps for this setting.
		calm = 1'b1;
		configure(5'd8, 5'd4, 5'd5);
		random_phase();
		calm = 1'b0;
		configure(5'd0, 5'd0, 5'd9);
		random_phase();
		configure(5'd31, 5'd31, 5'd31);
		write_cfg(CFG_SPARE, 5'd0);
		random_phase();
		configure(5'd17, 5'd5, 5'($urandom_range(0, 31)));
		random_phase();
		configure(5'($urandom), 5'($urandom), 5'($urandom));
		random_phase();

		$display("Ran %0d commands under %0d register settings; %0d driver words were checked.",
			model.commands_taken, settings_used, model.words_seen);
		if (model.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches found.", model.mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lmfb_pkg.sv
rtl/core/lmfb_ctrl.sv
rtl/core/lmfb_dp.sv
rtl/core/led_matrix_frame_buffer_refresh_core.sv
sim/testbench.sv
